/* hdl/utf8_ansi_text_sanitizer_macros.svh */
// Assertion macros shared by the sanitizer modules.
// Each macro takes a label, the clock, the active-low reset, the terms and a message.
`ifndef UTF8_ANSI_TEXT_SANITIZER_MACROS_SVH
`define UTF8_ANSI_TEXT_SANITIZER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define UTF8S_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define UTF8S_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define UTF8S_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/utf8s_pkg.sv */
`default_nettype none

package utf8s_pkg;

  // Decoder modes.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_CSI    = 3'd2,
    MODE_E2A    = 3'd3,
    MODE_E2B    = 3'd4,
    MODE_SKIP   = 3'd5
  } mode_t;

  // Byte values the decoder looks for.
  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
  localparam logic [7:0] BYTE_LOWER_M = 8'h6D;
  localparam logic [7:0] BYTE_LOWER_H = 8'h68;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_E2      = 8'hE2;
  localparam logic [7:0] BYTE_80      = 8'h80;
  localparam logic [7:0] BYTE_LDQUOTE = 8'h9C;
  localparam logic [7:0] BYTE_RDQUOTE = 8'h9D;
  localparam logic [7:0] BYTE_LSQUOTE = 8'h98;
  localparam logic [7:0] BYTE_RSQUOTE = 8'h99;
  localparam logic [7:0] BYTE_EMDASH  = 8'h94;
  localparam logic [7:0] BYTE_LEAD    = 8'hC0;

  // Characters the decoder produces.
  localparam logic [6:0] CHAR_CR     = 7'h0D;
  localparam logic [6:0] CHAR_SPACE  = 7'h20;
  localparam logic [6:0] CHAR_DQUOTE = 7'h22;
  localparam logic [6:0] CHAR_APOS   = 7'h27;
  localparam logic [6:0] CHAR_DASH   = 7'h2D;

  // One result beat.
  typedef struct packed {
    logic [6:0] ch;
    logic       run_end;
  } res_ent_t;

  // Results caused by one input beat, first result in ent0.
  typedef struct packed {
    logic [1:0] n;
    res_ent_t   ent0;
    res_ent_t   ent1;
  } res_bundle_t;

  // Outcome of a byte handled as plain text.
  typedef struct packed {
    logic       emit;
    logic [6:0] ch;
    mode_t      mode;
  } nb_t;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // A byte seen in normal text mode.
  function automatic nb_t normal_byte(input logic [7:0] b, input logic last);
    nb_t r;
    r.emit = 1'b0;
    r.ch   = CHAR_SPACE;
    r.mode = MODE_NORMAL;
    priority if (b == BYTE_ESC) begin
      r.mode = MODE_ESC;
    end else if (!b[7]) begin
      r.emit = 1'b1;
      r.ch   = (b == BYTE_LF) ? CHAR_CR : b[6:0];
    end else if (b == BYTE_E2 && !last) begin
      r.mode = MODE_E2A;
    end else if (b >= BYTE_LEAD) begin
      r.emit = 1'b1;
      r.mode = MODE_SKIP;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  // Three-byte sequences led by E2.
  function automatic logic [6:0] map_e2(input logic [7:0] b2, input logic [7:0] b3);
    logic [6:0] c;
    c = CHAR_SPACE;
    if (b2 == BYTE_80) begin
      if (b3 == BYTE_LDQUOTE || b3 == BYTE_RDQUOTE) begin
        c = CHAR_DQUOTE;
      end else if (b3 == BYTE_LSQUOTE || b3 == BYTE_RSQUOTE) begin
        c = CHAR_APOS;
      end else if (b3 == BYTE_EMDASH) begin
        c = CHAR_DASH;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/utf8s_decode.sv */
`default_nettype none

`include "utf8_ansi_text_sanitizer_macros.svh"

module utf8s_decode (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_final_byte,
  output utf8s_pkg::res_bundle_t      res
);

  utf8s_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]       held_r, held_nxt;

  // Decoder state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= utf8s_pkg::MODE_NORMAL;
      held_r <= 8'h00;
    end else if (accept) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

  // Next state and the results of the current byte.
  always_comb begin
    utf8s_pkg::nb_t nb;
    logic [1:0]     n;
    logic [6:0]     c0;
    logic [6:0]     c1;
    nb       = utf8s_pkg::normal_byte(in_byte, in_final_byte);
    n        = 2'd0;
    c0       = utf8s_pkg::CHAR_SPACE;
    c1       = utf8s_pkg::CHAR_SPACE;
    mode_nxt = mode_r;
    held_nxt = held_r;
    unique case (mode_r)
      utf8s_pkg::MODE_ESC: begin
        if (in_byte == utf8s_pkg::BYTE_LBRACK) begin
          mode_nxt = utf8s_pkg::MODE_CSI;
        end else begin
          n        = {1'b0, nb.emit};
          c0       = nb.ch;
          mode_nxt = nb.mode;
        end
      end
      utf8s_pkg::MODE_CSI: begin
        if (in_byte == utf8s_pkg::BYTE_LOWER_M || in_byte == utf8s_pkg::BYTE_LOWER_H) begin
          mode_nxt = utf8s_pkg::MODE_NORMAL;
        end
      end
      utf8s_pkg::MODE_E2A: begin
        if (!in_final_byte) begin
          held_nxt = in_byte;
          mode_nxt = utf8s_pkg::MODE_E2B;
        end else begin
          // The E2 was cut short: it gives a space, and the byte may give more.
          c0 = utf8s_pkg::CHAR_SPACE;
          if (utf8s_pkg::is_cont(in_byte)) begin
            n        = 2'd1;
            mode_nxt = utf8s_pkg::MODE_SKIP;
          end else begin
            n        = nb.emit ? 2'd2 : 2'd1;
            c1       = nb.ch;
            mode_nxt = nb.mode;
          end
        end
      end
      utf8s_pkg::MODE_E2B: begin
        n        = 2'd1;
        c0       = utf8s_pkg::map_e2(held_r, in_byte);
        held_nxt = 8'h00;
        mode_nxt = utf8s_pkg::MODE_NORMAL;
      end
      utf8s_pkg::MODE_SKIP: begin
        if (!utf8s_pkg::is_cont(in_byte)) begin
          n        = {1'b0, nb.emit};
          c0       = nb.ch;
          mode_nxt = nb.mode;
        end
      end
      default: begin
        n        = {1'b0, nb.emit};
        c0       = nb.ch;
        mode_nxt = nb.mode;
      end
    endcase

    // The end of a text always leaves the decoder ready for a new one.
    if (in_final_byte) begin
      mode_nxt = utf8s_pkg::MODE_NORMAL;
      held_nxt = 8'h00;
    end

    res.n            = n;
    res.ent0.ch      = c0;
    res.ent0.run_end = (n == 2'd1);
    res.ent1.ch      = c1;
    res.ent1.run_end = 1'b1;
  end

  `UTF8S_ASSERT_NEXT(a_final_clears, clk, rst_n, accept && in_final_byte, mode_r == utf8s_pkg::MODE_NORMAL && held_r == 8'h00, "final beat did not return decoder to normal mode")
  `UTF8S_ASSERT_IMPLY(a_two_only_cut_e2, clk, rst_n, res.n == 2'd2, mode_r == utf8s_pkg::MODE_E2A && in_final_byte, "two results outside a cut-short E2 sequence")
  `UTF8S_ASSERT_ALWAYS(a_n_range, clk, rst_n, res.n != 2'd3, "more than two results for one beat")

endmodule

`default_nettype wire

/* hdl/utf8s_outq.sv */
`default_nettype none

`include "utf8_ansi_text_sanitizer_macros.svh"

module utf8s_outq #(
  parameter int QDEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push_en,
  input  wire utf8s_pkg::res_bundle_t push_data,
  output logic                        full,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [6:0]                  out_char,
  output logic                        out_run_end
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  utf8s_pkg::res_ent_t q_r [QDEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]          push_n;
  logic                pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Room for two results is kept free so any beat can be taken.
  assign full      = cnt_r > CW'(QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign push_n    = push_en ? push_data.n : 2'd0;
  assign wr_ptr1   = ptr_inc(wr_ptr_r);

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage: up to two entries written per beat.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= push_data.ent0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr1] <= push_data.ent1;
    end
  end

  assign out_char    = q_r[rd_ptr_r].ch;
  assign out_run_end = q_r[rd_ptr_r].run_end;

  `UTF8S_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(QDEPTH), "result queue overfilled")
  `UTF8S_ASSERT_NEXT(a_cnt_track, clk, rst_n, !pop, cnt_r == $past(cnt_r) + CW'($past(push_n)), "result queue count lost a push")

endmodule

`default_nettype wire

/* hdl/utf8_ansi_text_sanitizer.sv */
// Channel  | Ports                                 | Direction | Beat
// ---------+---------------------------------------+-----------+-----------------------
// input    | in_valid in_stall in_byte in_final_byte | in      | one raw text byte
// result   | out_valid out_stall out_char out_run_end | out    | one ASCII character
//
// A byte is decoded in the cycle it is accepted; its results are registered in the result queue.
// One byte per cycle is sustained while the result side drains one beat per cycle.
// A byte can give two results, so the result queue sets the rate: in_stall rises
// while fewer than two queue entries are free.
// rst_n is synchronous, active low, and empties the queue and clears decode state.
`default_nettype none

module utf8_ansi_text_sanitizer #(
  parameter int QDEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_char,
  output logic            out_run_end
);

  utf8s_pkg::res_bundle_t res;
  logic                   accept;

  assign accept = in_valid && !in_stall;

  // Byte decoder and escape tracker.
  utf8s_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .res           (res)
  );

  // Result queue parting the two channels.
  utf8s_outq #(
    .QDEPTH (QDEPTH)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_en     (accept),
    .push_data   (res),
    .full        (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_run_end (out_run_end)
  );

endmodule

`default_nettype wire
